// ===== hw/rtl/ttlg_pkg.sv =====
// ============================================================================
// ttlg_pkg: shared types and constants for the thermal throttle governor.
// Holds the field widths, throttle level codes, register indexes, register
// reset values and the fixed frequency caps.
// ============================================================================
`default_nettype none

package ttlg_pkg;

    // Field widths.
    localparam int TEMP_W  = 8;
    localparam int KHZ_W   = 22;
    localparam int LEVEL_W = 2;
    localparam int CFG_IDX_W = 3;

    // Throttle levels.
    typedef enum logic [LEVEL_W-1:0] {
        LVL_NONE = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_MID  = 2'd2,
        LVL_MAX  = 2'd3
    } level_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHUTDOWN  = 3'd0,
        REG_LOW_TRIP  = 3'd1,
        REG_LOW_CLEAR = 3'd2,
        REG_MID_TRIP  = 3'd3,
        REG_MID_CLEAR = 3'd4,
        REG_MAX_TRIP  = 3'd5,
        REG_MAX_CLEAR = 3'd6
    } cfg_idx_t;

    // Threshold reset values in degrees Celsius.
    localparam logic [TEMP_W-1:0] RST_SHUTDOWN  = 8'd88;
    localparam logic [TEMP_W-1:0] RST_LOW_TRIP  = 8'd79;
    localparam logic [TEMP_W-1:0] RST_LOW_CLEAR = 8'd73;
    localparam logic [TEMP_W-1:0] RST_MID_TRIP  = 8'd81;
    localparam logic [TEMP_W-1:0] RST_MID_CLEAR = 8'd76;
    localparam logic [TEMP_W-1:0] RST_MAX_TRIP  = 8'd84;
    localparam logic [TEMP_W-1:0] RST_MAX_CLEAR = 8'd80;

    // Frequency caps in kHz.
    localparam logic [KHZ_W-1:0] LOW_CAP_KHZ  = 22'd1350000;
    localparam logic [KHZ_W-1:0] MID_CAP_KHZ  = 22'd810000;
    localparam logic [KHZ_W-1:0] MAX_CAP_KHZ  = 22'd384000;
    localparam logic [KHZ_W-1:0] FALLBACK_KHZ = 22'd1890000;

    // One result item.
    typedef struct packed {
        logic             ceiling_update;
        logic [KHZ_W-1:0] ceiling_khz;
        level_t           level;
        logic             shutdown;
        logic             wake_cores;
        logic             fallback_used;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/thermal_throttle_level_governor_top.sv =====
// ============================================================================
// thermal_throttle_level_governor_top: multi-level thermal throttle with
// hysteresis.
// A sample passes through the input register, then the result register.
// Throughput: one sample per cycle while out_ready does not stall the
// result register, set by the single compare-and-select pass between the
// two registers.
// Reset: thresholds return to their defaults, level and saved ceiling clear,
// both pipeline stages empty. No clearing pass is needed.
// ============================================================================
`default_nettype none

module thermal_throttle_level_governor_top
    import ttlg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Configuration write channel.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TEMP_W-1:0]    cfg_data,

    // Sample input channel.
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 sensor_ok,
    input  wire logic [TEMP_W-1:0]    temperature,
    input  wire logic [KHZ_W-1:0]     current_ceiling_khz,

    // Result output channel.
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      ceiling_update,
    output logic [KHZ_W-1:0]          ceiling_khz,
    output logic [LEVEL_W-1:0]        level,
    output logic                      shutdown,
    output logic                      wake_cores,
    output logic                      fallback_used
);

    // Threshold registers.
    logic [TEMP_W-1:0] sd_thr_reg;
    logic [TEMP_W-1:0] lo_trip_reg;
    logic [TEMP_W-1:0] lo_clr_reg;
    logic [TEMP_W-1:0] md_trip_reg;
    logic [TEMP_W-1:0] md_clr_reg;
    logic [TEMP_W-1:0] mx_trip_reg;
    logic [TEMP_W-1:0] mx_clr_reg;

    // Governor state.
    level_t            level_reg;
    level_t            level_next;
    logic [KHZ_W-1:0]  saved_reg;
    logic [KHZ_W-1:0]  saved_next;

    // Input stage.
    logic              s1_valid_reg;
    logic              s1_ok_reg;
    logic [TEMP_W-1:0] s1_temp_reg;
    logic [KHZ_W-1:0]  s1_cur_reg;

    // Result stage.
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;

    // Handshake control.
    logic              in_xfer;
    logic              s2_free;
    logic              advance;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_thr_reg  <= RST_SHUTDOWN;
            lo_trip_reg <= RST_LOW_TRIP;
            lo_clr_reg  <= RST_LOW_CLEAR;
            md_trip_reg <= RST_MID_TRIP;
            md_clr_reg  <= RST_MID_CLEAR;
            mx_trip_reg <= RST_MAX_TRIP;
            mx_clr_reg  <= RST_MAX_CLEAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHUTDOWN:  sd_thr_reg  <= cfg_data;
                REG_LOW_TRIP:  lo_trip_reg <= cfg_data;
                REG_LOW_CLEAR: lo_clr_reg  <= cfg_data;
                REG_MID_TRIP:  md_trip_reg <= cfg_data;
                REG_MID_CLEAR: md_clr_reg  <= cfg_data;
                REG_MAX_TRIP:  mx_trip_reg <= cfg_data;
                REG_MAX_CLEAR: mx_clr_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The result stage frees up when empty or when its transfer completes.
    assign s2_free   = !out_valid_reg || out_ready;
    assign advance   = s1_valid_reg && s2_free;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign in_xfer   = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_ok_reg   <= sensor_ok;
            s1_temp_reg <= temperature;
            s1_cur_reg  <= current_ceiling_khz;
        end
    end

    // Shutdown check, ceiling save and the ordered trip/clear checks.
    always_comb
    begin
        level_t           lvl;
        logic [KHZ_W-1:0] saved;

        lvl        = level_reg;
        saved      = saved_reg;
        res_next   = '0;
        res_next.level = level_reg;
        level_next = level_reg;
        saved_next = saved_reg;

        if (s1_ok_reg)
        begin
            if (s1_temp_reg >= sd_thr_reg)
            begin
                res_next.shutdown = 1'b1;
                lvl = LVL_MAX;
            end

            // The ceiling is only saved while unthrottled.
            if (lvl == LVL_NONE)
            begin
                saved = s1_cur_reg;
            end

            if (s1_temp_reg >= lo_trip_reg && s1_temp_reg < md_trip_reg
                && lvl == LVL_NONE)
            begin
                res_next.ceiling_update = 1'b1;
                res_next.ceiling_khz    = LOW_CAP_KHZ;
                lvl = LVL_LOW;
            end
            else if (s1_temp_reg < lo_clr_reg && lvl != LVL_NONE)
            begin
                // Full clear: restore the saved ceiling or fall back.
                res_next.ceiling_update = 1'b1;
                res_next.wake_cores     = 1'b1;
                if (saved != '0)
                begin
                    res_next.ceiling_khz = saved;
                end
                else
                begin
                    res_next.ceiling_khz   = FALLBACK_KHZ;
                    res_next.fallback_used = 1'b1;
                end
                lvl = LVL_NONE;
            end
            else if (s1_temp_reg >= md_trip_reg && s1_temp_reg < mx_trip_reg
                     && (lvl == LVL_NONE || lvl == LVL_LOW))
            begin
                res_next.ceiling_update = 1'b1;
                res_next.ceiling_khz    = MID_CAP_KHZ;
                lvl = LVL_MID;
            end
            else if (s1_temp_reg < md_clr_reg
                     && (lvl == LVL_MID || lvl == LVL_MAX))
            begin
                res_next.ceiling_update = 1'b1;
                res_next.ceiling_khz    = LOW_CAP_KHZ;
                lvl = LVL_LOW;
            end
            else if (s1_temp_reg >= mx_trip_reg)
            begin
                res_next.ceiling_update = 1'b1;
                res_next.ceiling_khz    = MAX_CAP_KHZ;
                lvl = LVL_MAX;
            end
            else if (s1_temp_reg < mx_clr_reg && lvl == LVL_MAX)
            begin
                res_next.ceiling_update = 1'b1;
                res_next.ceiling_khz    = MID_CAP_KHZ;
                lvl = LVL_MID;
            end

            res_next.level = lvl;
            level_next     = lvl;
            saved_next     = saved;
        end
    end

    // State moves forward with each sample that enters the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LVL_NONE;
            saved_reg <= '0;
        end
        else if (advance)
        begin
            level_reg <= level_next;
            saved_reg <= saved_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Output ports.
    assign out_valid      = out_valid_reg;
    assign ceiling_update = res_reg.ceiling_update;
    assign ceiling_khz    = res_reg.ceiling_khz;
    assign level          = res_reg.level;
    assign shutdown       = res_reg.shutdown;
    assign wake_cores     = res_reg.wake_cores;
    assign fallback_used  = res_reg.fallback_used;

    // A full clear always carries a ceiling update and leaves level zero.
    a_wake_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wake_cores |-> ceiling_update && level == LVL_NONE)
        else $error("wake_cores without a full clear");

    // The fallback ceiling only appears on a full clear.
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fallback_used |-> wake_cores && ceiling_khz == FALLBACK_KHZ)
        else $error("fallback_used outside a full clear");

    // No ceiling value leaks out without an update.
    a_no_stray_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ceiling_update |-> ceiling_khz == '0)
        else $error("ceiling_khz nonzero without ceiling_update");

    // Governor state changes only when a sample enters the result stage.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(level_reg) && $stable(saved_reg))
        else $error("governor state changed without a sample");

endmodule

`default_nettype wire

// ===== sim/throttle_result_check.sv =====
// ============================================================================
// throttle_result_check: result predictor and comparator for the governor.
// Watches the configuration, sample and result channels, keeps its own copy
// of the thresholds, the throttle level and the saved ceiling, predicts one
// result per sample transfer and compares every result transfer field by
// field against the oldest prediction.
// ============================================================================
module throttle_result_check
    import ttlg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 sensor_ok,
    input  logic [TEMP_W-1:0]    temperature,
    input  logic [KHZ_W-1:0]     current_ceiling_khz,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 ceiling_update,
    input  logic [KHZ_W-1:0]     ceiling_khz,
    input  logic [LEVEL_W-1:0]   level,
    input  logic                 shutdown,
    input  logic                 wake_cores,
    input  logic                 fallback_used,
    output int                   pending_results,
    output int                   mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int THRESHOLD_COUNT = int'(REG_MAX_CLEAR) + 1;

    // Shadow copy of the thresholds and the governor state.
    logic [TEMP_W-1:0] thresholds [THRESHOLD_COUNT];
    level_t            level_q;
    logic [KHZ_W-1:0]  saved_khz;

    // Predicted results, oldest first.
    result_t predicted_results [$];

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compute the result of one sample and advance the shadow state.
    function automatic result_t step_governor(input logic ok, input logic [TEMP_W-1:0] t,
                                              input logic [KHZ_W-1:0] cur);
        result_t r;
        level_t  lvl;
        r   = '0;
        lvl = level_q;
        if (ok) begin
            // Shutdown forces max level before the ceiling is saved.
            if (t >= thresholds[REG_SHUTDOWN]) begin
                r.shutdown = 1'b1;
                lvl        = LVL_MAX;
            end
            if (lvl == LVL_NONE)
                saved_khz = cur;

            // Only the first matching trip or clear point applies.
            if (t >= thresholds[REG_LOW_TRIP] && t < thresholds[REG_MID_TRIP]
                && lvl == LVL_NONE) begin
                r.ceiling_update = 1'b1;
                r.ceiling_khz    = LOW_CAP_KHZ;
                lvl              = LVL_LOW;
            end else if (t < thresholds[REG_LOW_CLEAR] && lvl != LVL_NONE) begin
                r.ceiling_update = 1'b1;
                r.wake_cores     = 1'b1;
                if (saved_khz != '0) begin
                    r.ceiling_khz = saved_khz;
                end else begin
                    r.ceiling_khz   = FALLBACK_KHZ;
                    r.fallback_used = 1'b1;
                end
                lvl = LVL_NONE;
            end else if (t >= thresholds[REG_MID_TRIP] && t < thresholds[REG_MAX_TRIP]
                         && lvl < LVL_MID) begin
                r.ceiling_update = 1'b1;
                r.ceiling_khz    = MID_CAP_KHZ;
                lvl              = LVL_MID;
            end else if (t < thresholds[REG_MID_CLEAR] && lvl > LVL_LOW) begin
                r.ceiling_update = 1'b1;
                r.ceiling_khz    = LOW_CAP_KHZ;
                lvl              = LVL_LOW;
            end else if (t >= thresholds[REG_MAX_TRIP]) begin
                r.ceiling_update = 1'b1;
                r.ceiling_khz    = MAX_CAP_KHZ;
                lvl              = LVL_MAX;
            end else if (t < thresholds[REG_MAX_CLEAR] && lvl == LVL_MAX) begin
                r.ceiling_update = 1'b1;
                r.ceiling_khz    = MID_CAP_KHZ;
                lvl              = LVL_MID;
            end
            level_q = lvl;
        end
        r.level = lvl;
        return r;
    endfunction

    // Compare one result transfer against the oldest prediction.
    task automatic check_result();
        result_t want;
        if (predicted_results.size() == 0) begin
            report_mismatch("result transfer with no sample outstanding");
            return;
        end
        want = predicted_results.pop_front();
        if (ceiling_update !== want.ceiling_update)
            report_mismatch($sformatf("ceiling_update got %0b expected %0b",
                                      ceiling_update, want.ceiling_update));
        if (ceiling_khz !== want.ceiling_khz)
            report_mismatch($sformatf("ceiling_khz got %0d expected %0d",
                                      ceiling_khz, want.ceiling_khz));
        if (level !== want.level)
            report_mismatch($sformatf("level got %0d expected %0d", level, want.level));
        if (shutdown !== want.shutdown)
            report_mismatch($sformatf("shutdown got %0b expected %0b",
                                      shutdown, want.shutdown));
        if (wake_cores !== want.wake_cores)
            report_mismatch($sformatf("wake_cores got %0b expected %0b",
                                      wake_cores, want.wake_cores));
        if (fallback_used !== want.fallback_used)
            report_mismatch($sformatf("fallback_used got %0b expected %0b",
                                      fallback_used, want.fallback_used));
    endtask

    // Channel monitor. Results are checked before new samples are predicted,
    // so a result in the same cycle can never match its own sample.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thresholds[REG_SHUTDOWN]  = RST_SHUTDOWN;
            thresholds[REG_LOW_TRIP]  = RST_LOW_TRIP;
            thresholds[REG_LOW_CLEAR] = RST_LOW_CLEAR;
            thresholds[REG_MID_TRIP]  = RST_MID_TRIP;
            thresholds[REG_MID_CLEAR] = RST_MID_CLEAR;
            thresholds[REG_MAX_TRIP]  = RST_MAX_TRIP;
            thresholds[REG_MAX_CLEAR] = RST_MAX_CLEAR;
            level_q   = LVL_NONE;
            saved_khz = '0;
            predicted_results.delete();
            pending_results <= 0;
        end else begin
            if (out_valid && out_ready)
                check_result();
            // Writes to an index past the last register are dropped.
            if (cfg_valid && cfg_ready && cfg_index <= REG_MAX_CLEAR)
                thresholds[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                predicted_results.push_back(step_governor(sensor_ok, temperature,
                                                          current_ceiling_khz));
            pending_results <= predicted_results.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ============================================================================
// testbench: stimulus and verdict for the thermal throttle governor.
// Runs a directed sequence through every trip and clear transition, then
// random temperature walks around several threshold settings, extremes
// included, with random gaps on the sample and result channels.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ttlg_pkg::*;

    localparam int THRESHOLD_COUNT = int'(REG_MAX_CLEAR) + 1;
    localparam int DRAIN_CYCLES    = 4;
    localparam int PHASES          = 9;
    localparam int TEMP_MAX        = (1 << TEMP_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

    typedef logic [TEMP_W-1:0] threshold_set_t [THRESHOLD_COUNT];

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TEMP_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 sensor_ok = 1'b0;
    logic [TEMP_W-1:0]    temperature = '0;
    logic [KHZ_W-1:0]     current_ceiling_khz = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 ceiling_update;
    logic [KHZ_W-1:0]     ceiling_khz;
    logic [LEVEL_W-1:0]   level;
    logic                 shutdown;
    logic                 wake_cores;
    logic                 fallback_used;
    int                   pending_results;
    int                   mismatch_count;
    bit                   no_idle = 1'b0;

    always #1 clk = ~clk;

    thermal_throttle_level_governor_top dut (.*);

    throttle_result_check result_check (.*);

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Ceiling mix with zero and all-ones showing up often.
    function automatic logic [KHZ_W-1:0] pick_ceiling();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return KHZ_W'($urandom);
    endfunction

    // Temperature walk: small steps, jumps next to a threshold, some noise.
    function automatic logic [TEMP_W-1:0] next_temperature(input logic [TEMP_W-1:0] prev,
                                                           input threshold_set_t set);
        int r;
        int t;
        r = $urandom_range(99);
        if (r < 10)
            return TEMP_W'($urandom);
        if (r < 22)
            t = int'(set[$urandom_range(THRESHOLD_COUNT - 1)]) + int'($urandom_range(2)) - 1;
        else
            t = int'(prev) + int'($urandom_range(8)) - 4;
        if (t < 0)
            t = 0;
        if (t > TEMP_MAX)
            t = TEMP_MAX;
        return TEMP_W'(t);
    endfunction

    // One sample transfer; valid stays high afterwards unless a gap follows.
    task automatic send_sample(input logic ok, input logic [TEMP_W-1:0] t,
                               input logic [KHZ_W-1:0] cur);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        sensor_ok           <= ok;
        temperature         <= t;
        current_ceiling_khz <= cur;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all thresholds back to back, then one write to an unused index.
    task automatic program_thresholds(input threshold_set_t set);
        cfg_valid <= 1'b1;
        for (int k = 0; k < THRESHOLD_COUNT; k++) begin
            cfg_index <= cfg_idx_t'(k);
            cfg_data  <= set[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_index <= REG_UNUSED;
        cfg_data  <= TEMP_W'($urandom);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure: ready runs broken by stalls.
    initial begin
        int run;
        int stall;
        forever begin
            run   = $urandom_range(1, 24);
            stall = pick_gap();
            repeat (run) begin
                @(posedge clk);
                out_ready <= 1'b1;
            end
            repeat (stall) begin
                @(posedge clk);
                out_ready <= 1'b0;
            end
        end
    end

    // Main stimulus.
    initial begin
        threshold_set_t    set;
        logic [TEMP_W-1:0] t;
        int                n;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk at the reset thresholds.
        send_sample(1'b0, 8'd255, '1);       // failed read changes nothing
        send_sample(1'b1, 8'd0, '0);         // idle, saves a zero ceiling
        send_sample(1'b1, 8'd79, '0);        // low trip
        send_sample(1'b1, 8'd72, '1);        // full clear, fallback frequency
        send_sample(1'b1, 8'd80, '1);        // saves all-ones, low trip
        send_sample(1'b1, 8'd81, '0);        // mid trip
        send_sample(1'b1, 8'd75, '0);        // mid clear back to low
        send_sample(1'b1, 8'd84, '0);        // max trip
        send_sample(1'b1, 8'd87, '0);        // max trip repeats the cap
        send_sample(1'b1, 8'd79, '0);        // max clear back to mid
        send_sample(1'b1, 8'd84, '0);
        send_sample(1'b0, 8'd0, '0);         // failed read while at max
        send_sample(1'b1, 8'd72, '0);        // full clear to the saved ceiling
        send_sample(1'b1, 8'd88, 22'd12345); // shutdown from idle must not save
        send_sample(1'b1, 8'd255, '0);
        send_sample(1'b1, 8'd0, '0);
        send_sample(1'b1, 8'd73, 22'd5);     // idle, no match, saves
        send_sample(1'b1, 8'd82, '0);        // straight from idle to mid
        send_sample(1'b1, 8'd0, '0);

        // Shutdown with no later match: level forced to max, no update.
        wait_drain();
        set = '{8'd50, 8'd60, 8'd10, 8'd100, 8'd20, 8'd200, 8'd40};
        program_thresholds(set);
        send_sample(1'b1, 8'd150, '1);
        send_sample(1'b1, 8'd50, '0);
        send_sample(1'b1, 8'd5, '0);

        // Random phases over a spread of threshold settings.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: foreach (set[k]) set[k] = '0;
                1: foreach (set[k]) set[k] = '1;
                2: set = '{RST_SHUTDOWN, RST_LOW_TRIP, RST_LOW_CLEAR, RST_MID_TRIP,
                           RST_MID_CLEAR, RST_MAX_TRIP, RST_MAX_CLEAR};
                4, 6: foreach (set[k]) set[k] = TEMP_W'($urandom);
                default: begin
                    // Consistent ordering with random spacing.
                    set[REG_LOW_CLEAR] = TEMP_W'($urandom_range(180));
                    set[REG_MID_CLEAR] = set[REG_LOW_CLEAR] + TEMP_W'($urandom_range(1, 6));
                    set[REG_LOW_TRIP]  = set[REG_MID_CLEAR] + TEMP_W'($urandom_range(1, 6));
                    set[REG_MAX_CLEAR] = set[REG_LOW_TRIP] + TEMP_W'($urandom_range(4));
                    set[REG_MID_TRIP]  = set[REG_MAX_CLEAR] + TEMP_W'($urandom_range(1, 4));
                    set[REG_MAX_TRIP]  = set[REG_MID_TRIP] + TEMP_W'($urandom_range(1, 6));
                    set[REG_SHUTDOWN]  = set[REG_MAX_TRIP] + TEMP_W'($urandom_range(1, 8));
                end
            endcase
            wait_drain();
            no_idle = (p == 2);
            program_thresholds(set);
            n = (p < 2) ? 40 : 160;
            t = set[REG_LOW_TRIP];
            for (int i = 0; i < n; i++) begin
                // Let the pipeline empty once in the middle of a phase.
                if (p == 4 && i == n / 2)
                    wait_drain();
                t = next_temperature(t, set);
                send_sample($urandom_range(9) != 0, t, pick_ceiling());
            end
        end

        wait_drain();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
